FILE: rtl/core/tfbp_pkg.sv
// ----------------------------------------------------------------------------
// tfbp_pkg
// Shared types, register indexes and command helpers for the tile fill
// blit planner.
// ----------------------------------------------------------------------------
package tfbp_pkg;

   // internal coordinate width: wide enough for window centering without wrap
   localparam int CW = 18;
   localparam int MOD_STEPS = 16;

   typedef logic signed [CW-1:0] crd_type;
   typedef logic [14:0] len_type;
   typedef logic [2:0] csr_idx_type;
   typedef logic [1:0] kind_type;

   localparam len_type LEN_MAX = 15'h7FFF;

   localparam csr_idx_type CSR_PATTERN_WIDTH  = 3'd0;
   localparam csr_idx_type CSR_PATTERN_HEIGHT = 3'd1;
   localparam csr_idx_type CSR_CENTER_MODE    = 3'd2;
   localparam csr_idx_type CSR_PATTERN_READY  = 3'd3;
   localparam csr_idx_type CSR_BORDER_PEN     = 3'd4;

   localparam kind_type KIND_PATTERN = 2'd0;
   localparam kind_type KIND_COPY    = 2'd1;
   localparam kind_type KIND_FILL    = 2'd2;

   typedef struct packed {
      logic signed [15:0] rect_min_x;
      logic signed [15:0] rect_min_y;
      logic signed [15:0] rect_max_x;
      logic signed [15:0] rect_max_y;
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_y;
      logic signed [15:0] layer_min_x;
      logic signed [15:0] layer_min_y;
      logic signed [15:0] layer_max_x;
      logic signed [15:0] layer_max_y;
      logic               has_layer;
      logic               skip_pattern;
   } req_type;

   typedef struct packed {
      kind_type           cmd_kind;
      logic signed [15:0] src_x;
      logic signed [15:0] src_y;
      logic signed [15:0] dst_x;
      logic signed [15:0] dst_y;
      len_type            size_w;
      len_type            size_h;
      logic [7:0]         fill_pen;
      logic               last;
   } rsp_type;

   // modulo unit request / response
   typedef struct packed {
      logic               start;
      logic signed [15:0] dividend;
      len_type            divisor;
   } mod_req_type;

   typedef struct packed {
      logic    done;
      len_type result;
   } mod_rsp_type;

   function automatic crd_type sext(input logic signed [15:0] v);
      return crd_type'(v);
   endfunction

   function automatic crd_type len2crd(input len_type v);
      return crd_type'({3'b000, v});
   endfunction

   function automatic crd_type crd_min(input crd_type a, input crd_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic crd_type crd_max(input crd_type a, input crd_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic len_type len_min(input len_type a, input len_type b);
      return (a < b) ? a : b;
   endfunction

   // build one command; coordinates wrap to 16 bits, sizes to 15 bits
   function automatic rsp_type make_cmd(input kind_type k,
                                        input crd_type  sx,
                                        input crd_type  sy,
                                        input crd_type  dx,
                                        input crd_type  dy,
                                        input crd_type  w,
                                        input crd_type  h,
                                        input logic [7:0] pen);
      rsp_type c;
      c.cmd_kind = k;
      c.src_x    = sx[15:0];
      c.src_y    = sy[15:0];
      c.dst_x    = dx[15:0];
      c.dst_y    = dy[15:0];
      c.size_w   = w[14:0];
      c.size_h   = h[14:0];
      c.fill_pen = pen;
      c.last     = 1'b0;
      return c;
   endfunction

endpackage

FILE: rtl/core/tile_fill_blit_planner.sv
// ----------------------------------------------------------------------------
// tile_fill_blit_planner
// Turns one backfill transaction (rectangle, pattern offset, window, flags)
// into the ordered run of blitter commands: a plain pen fill, wrapped
// pattern pieces plus doubling copies, or a centered clipped blit plus
// border fills.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake               payload
//   -------   ---   ---------------------   ---------------------------
//   req_*     in    req_valid / req_stall   req_data  (tfbp_pkg::req_type)
//   rsp_*     out   rsp_valid / rsp_stall   rsp_data  (tfbp_pkg::rsp_type)
//   csr_*     in    csr_we                  csr_index, csr_wdata
//
// Operation: one transaction at a time. Tile mode setup makes two passes
//   through the shared modulo unit, x then y, before its commands.
// Rate is set by the modulo unit and by the single command emit port.
// Reset: synchronous, active high; state and configuration registers return
//   to their defaults, output and hold stages empty.
// rsp_stall holds a full output register and so stalls command emission; req_stall is high while busy.
//
module tile_fill_blit_planner (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tfbp_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tfbp_pkg::rsp_type     rsp_data,
   input  logic                  csr_we,
   input  tfbp_pkg::csr_idx_type csr_index,
   input  tfbp_pkg::len_type     csr_wdata
);
   import tfbp_pkg::*;

   typedef enum logic [16:0] {
      ST_IDLE   = 17'h00001,
      ST_PREP   = 17'h00002,
      ST_PLAIN  = 17'h00004,
      ST_MODX   = 17'h00008,
      ST_MODY   = 17'h00010,
      ST_TSIZE  = 17'h00020,
      ST_TSTEP  = 17'h00040,
      ST_TILE   = 17'h00080,
      ST_ACROSS = 17'h00100,
      ST_DOWN   = 17'h00200,
      ST_CWIN   = 17'h00400,
      ST_CORG   = 17'h00800,
      ST_CEND   = 17'h01000,
      ST_CCLIP  = 17'h02000,
      ST_CSPAN  = 17'h04000,
      ST_CFILL  = 17'h08000,
      ST_FLUSH  = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   len_type    pw_ff, ph_ff;
   logic       center_ff, ready_ff;
   logic [7:0] pen_ff;

   // transaction and derived geometry
   req_type    item_ff, item_in;
   crd_type    mxx_ff, mxx_in, mxy_ff, mxy_in;
   len_type    rw_ff, rw_in, rh_ff, rh_in;
   len_type    sx_ff, sx_in, sy_ff, sy_in;
   len_type    fw_ff, fw_in, fh_ff, fh_in;
   len_type    sw_ff, sw_in, sh_ff, sh_in;
   len_type    band_ff, band_in;
   logic [15:0] rel_ff, rel_in, size_ff, size_in;
   logic [2:0] piece_ff, piece_in;

   // center mode
   crd_type    x_ff, x_in, y_ff, y_in;
   crd_type    x1_ff, x1_in, y1_ff, y1_in;
   crd_type    bx0_ff, bx0_in, by0_ff, by0_in, bx1_ff, bx1_in, by1_ff, by1_in;
   crd_type    xl_ff, xl_in, xr_ff, xr_in;
   logic       fail0_ff, fail0_in, fail_ff, fail_in;

   // emit path: hold stage feeds the output register, so last can be set
   rsp_type    hold_ff, hold_in, rsp_ff, rsp_in;
   logic       hold_valid_ff, hold_valid_in, rsp_valid_ff, rsp_valid_in;

   logic        gen_valid;
   rsp_type     gen_cmd;
   logic        out_free, can_emit, emit_fire, flush_fire;

   mod_req_type mod_req;
   mod_rsp_type mod_rsp;

   // coordinates of the transaction
   crd_type mnx, mny, mxx_raw, mxy_raw, lx0, ly0, lx1, ly1;
   crd_type dwx, dwy, x2, y2;
   logic    empty, plain, ctr, sat_x, sat_y;
   logic    want, more;
   len_type axis_len;
   logic [15:0] rem16, cur;
   logic    xhi, yhi, f1x, f1y, fail_now;
   crd_type left_c, top_c;

   assign mnx     = sext(item_ff.rect_min_x);
   assign mny     = sext(item_ff.rect_min_y);
   assign mxx_raw = sext(item_ff.rect_max_x);
   assign mxy_raw = sext(item_ff.rect_max_y);
   assign lx0     = sext(item_ff.layer_min_x);
   assign ly0     = sext(item_ff.layer_min_y);
   assign lx1     = sext(item_ff.layer_max_x);
   assign ly1     = sext(item_ff.layer_max_y);

   assign empty = (item_ff.rect_max_x < item_ff.rect_min_x) ||
                  (item_ff.rect_max_y < item_ff.rect_min_y);
   assign plain = !ready_ff || item_ff.skip_pattern || pw_ff == '0 || ph_ff == '0;
   assign ctr   = center_ff && item_ff.has_layer;

   assign dwx   = mxx_raw - mnx + crd_type'(1);
   assign dwy   = mxy_raw - mny + crd_type'(1);
   assign sat_x = dwx > len2crd(LEN_MAX);
   assign sat_y = dwy > len2crd(LEN_MAX);

   assign x2 = mnx + len2crd(fw_ff);
   assign y2 = mny + len2crd(fh_ff);

   // shared doubling-copy step for both axes
   assign axis_len = (state_ff == ST_DOWN) ? rh_ff : rw_ff;
   assign more     = rel_ff < {1'b0, axis_len};
   assign rem16    = {1'b0, axis_len} - rel_ff;
   assign cur      = (size_ff < rem16) ? size_ff : rem16;

   // far-edge clipping of the centered tile
   assign xhi      = x1_ff > mxx_ff;
   assign yhi      = y1_ff > mxy_ff;
   assign f1x      = !xhi && (x1_ff < mnx);
   assign f1y      = !yhi && (y1_ff < mny);
   assign fail_now = fail0_ff || f1x || f1y;

   assign left_c = crd_max(mnx, bx1_ff + crd_type'(1));
   assign top_c  = crd_max(mny, by1_ff + crd_type'(1));

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign can_emit   = !hold_valid_ff || out_free;
   assign emit_fire  = gen_valid && can_emit;
   assign flush_fire = (state_ff == ST_FLUSH) && hold_valid_ff && out_free;

   // modulo requests: x in PREP, y once x is done
   always_comb begin
      mod_req.start    = ((state_ff == ST_PREP) && !empty && !plain && !ctr) ||
                         ((state_ff == ST_MODX) && mod_rsp.done);
      mod_req.dividend = (state_ff == ST_PREP) ? item_ff.offset_x : item_ff.offset_y;
      mod_req.divisor  = (state_ff == ST_PREP) ? pw_ff : ph_ff;
   end

   tfbp_mod u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   // command generator
   always_comb begin
      gen_valid = 1'b0;
      gen_cmd   = make_cmd(KIND_FILL, '0, '0, '0, '0, '0, '0, '0);
      want      = 1'b0;
      unique case (state_ff)
         ST_PLAIN: begin
            gen_valid = 1'b1;
            gen_cmd   = make_cmd(KIND_FILL, '0, '0, mnx, mny,
                                 len2crd(rw_ff), len2crd(rh_ff), pen_ff);
         end
         ST_TILE: begin
            unique case (piece_ff)
               3'd0: begin
                  want    = 1'b1;
                  gen_cmd = make_cmd(KIND_PATTERN, len2crd(sx_ff), len2crd(sy_ff),
                                     mnx, mny, len2crd(fw_ff), len2crd(fh_ff), '0);
               end
               3'd1: begin
                  want    = sw_ff != '0;
                  gen_cmd = make_cmd(KIND_PATTERN, '0, len2crd(sy_ff), x2, mny,
                                     len2crd(sw_ff), len2crd(fh_ff), '0);
               end
               3'd2: begin
                  want    = sh_ff != '0;
                  gen_cmd = make_cmd(KIND_PATTERN, len2crd(sx_ff), '0, mnx, y2,
                                     len2crd(fw_ff), len2crd(sh_ff), '0);
               end
               default: begin
                  want    = sw_ff != '0 && sh_ff != '0;
                  gen_cmd = make_cmd(KIND_PATTERN, '0, '0, x2, y2,
                                     len2crd(sw_ff), len2crd(sh_ff), '0);
               end
            endcase
            gen_valid = want;
         end
         ST_ACROSS: begin
            gen_valid = more;
            gen_cmd   = make_cmd(KIND_COPY, mnx, mny, mnx + crd_type'({2'b00, rel_ff}),
                                 mny, crd_type'({2'b00, cur}), len2crd(band_ff), '0);
         end
         ST_DOWN: begin
            gen_valid = more;
            gen_cmd   = make_cmd(KIND_COPY, mnx, mny, mnx, mny + crd_type'({2'b00, rel_ff}),
                                 len2crd(rw_ff), crd_type'({2'b00, cur}), '0);
         end
         ST_CFILL: begin
            unique case (piece_ff)
               3'd0: begin
                  // clipped tile blit
                  want    = !fail_ff;
                  gen_cmd = make_cmd(KIND_PATTERN, bx0_ff - x_ff, by0_ff - y_ff,
                                     bx0_ff, by0_ff,
                                     bx1_ff - bx0_ff + crd_type'(1),
                                     by1_ff - by0_ff + crd_type'(1), '0);
               end
               3'd1: begin
                  // left strip
                  want    = mnx < bx0_ff;
                  gen_cmd = make_cmd(KIND_FILL, '0, '0, mnx, mny,
                                     crd_min(mxx_ff, bx0_ff - crd_type'(1)) - mnx
                                        + crd_type'(1),
                                     len2crd(rh_ff), pen_ff);
               end
               3'd2: begin
                  // right strip
                  want    = mxx_ff > bx1_ff;
                  gen_cmd = make_cmd(KIND_FILL, '0, '0, left_c, mny,
                                     mxx_ff - left_c + crd_type'(1),
                                     len2crd(rh_ff), pen_ff);
               end
               3'd3: begin
                  // top strip, between the side strips
                  want    = (mny < by0_ff) && (xl_ff <= xr_ff);
                  gen_cmd = make_cmd(KIND_FILL, '0, '0, xl_ff, mny,
                                     xr_ff - xl_ff + crd_type'(1),
                                     crd_min(mxy_ff, by0_ff - crd_type'(1)) - mny
                                        + crd_type'(1),
                                     pen_ff);
               end
               default: begin
                  // bottom strip
                  want    = (mxy_ff > by1_ff) && (xl_ff <= xr_ff);
                  gen_cmd = make_cmd(KIND_FILL, '0, '0, xl_ff, top_c,
                                     xr_ff - xl_ff + crd_type'(1),
                                     mxy_ff - top_c + crd_type'(1), pen_ff);
               end
            endcase
            gen_valid = want;
         end
         default: begin
            gen_valid = 1'b0;
         end
      endcase
   end

   // sequencer and geometry
   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      mxx_in   = mxx_ff;
      mxy_in   = mxy_ff;
      rw_in    = rw_ff;
      rh_in    = rh_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      fw_in    = fw_ff;
      fh_in    = fh_ff;
      sw_in    = sw_ff;
      sh_in    = sh_ff;
      band_in  = band_ff;
      rel_in   = rel_ff;
      size_in  = size_ff;
      piece_in = piece_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      x1_in    = x1_ff;
      y1_in    = y1_ff;
      bx0_in   = bx0_ff;
      by0_in   = by0_ff;
      bx1_in   = bx1_ff;
      by1_in   = by1_ff;
      xl_in    = xl_ff;
      xr_in    = xr_ff;
      fail0_in = fail0_ff;
      fail_in  = fail_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // saturate oversized spans to 32767 pixels
            rw_in  = sat_x ? LEN_MAX : dwx[14:0];
            rh_in  = sat_y ? LEN_MAX : dwy[14:0];
            mxx_in = sat_x ? mnx + len2crd(LEN_MAX) - crd_type'(1) : mxx_raw;
            mxy_in = sat_y ? mny + len2crd(LEN_MAX) - crd_type'(1) : mxy_raw;
            priority if (empty) state_in = ST_IDLE;
            else if (plain)     state_in = ST_PLAIN;
            else if (ctr)       state_in = ST_CWIN;
            else                state_in = ST_MODX;
         end
         ST_PLAIN: begin
            if (emit_fire) state_in = ST_FLUSH;
         end
         ST_MODX: begin
            if (mod_rsp.done) begin
               sx_in    = mod_rsp.result;
               state_in = ST_MODY;
            end
         end
         ST_MODY: begin
            if (mod_rsp.done) begin
               sy_in    = mod_rsp.result;
               state_in = ST_TSIZE;
            end
         end
         ST_TSIZE: begin
            fw_in    = len_min(pw_ff - sx_ff, rw_ff);
            fh_in    = len_min(ph_ff - sy_ff, rh_ff);
            state_in = ST_TSTEP;
         end
         ST_TSTEP: begin
            sw_in    = len_min(sx_ff, rw_ff - fw_ff);
            sh_in    = len_min(sy_ff, rh_ff - fh_ff);
            band_in  = len_min(ph_ff, rh_ff);
            piece_in = '0;
            state_in = ST_TILE;
         end
         ST_TILE: begin
            if (!want || emit_fire) begin
               if (piece_ff == 3'd3) begin
                  rel_in   = {1'b0, pw_ff};
                  size_in  = {1'b0, pw_ff};
                  state_in = ST_ACROSS;
               end else begin
                  piece_in = piece_ff + 3'd1;
               end
            end
         end
         ST_ACROSS: begin
            if (!more) begin
               rel_in   = {1'b0, ph_ff};
               size_in  = {1'b0, ph_ff};
               state_in = ST_DOWN;
            end else if (emit_fire) begin
               rel_in  = rel_ff + cur;
               size_in = {cur[14:0], 1'b0};
            end
         end
         ST_DOWN: begin
            if (!more) begin
               state_in = ST_FLUSH;
            end else if (emit_fire) begin
               rel_in  = rel_ff + cur;
               size_in = {cur[14:0], 1'b0};
            end
         end
         ST_CWIN: begin
            // window size minus tile size
            x_in     = lx1 - lx0 + crd_type'(1) - len2crd(pw_ff);
            y_in     = ly1 - ly0 + crd_type'(1) - len2crd(ph_ff);
            state_in = ST_CORG;
         end
         ST_CORG: begin
            // halving rounds toward minus infinity
            x_in     = lx0 + (x_ff >>> 1);
            y_in     = ly0 + (y_ff >>> 1);
            state_in = ST_CEND;
         end
         ST_CEND: begin
            x1_in    = x_ff + len2crd(pw_ff) - crd_type'(1);
            y1_in    = y_ff + len2crd(ph_ff) - crd_type'(1);
            bx0_in   = (x_ff < mnx) ? mnx : x_ff;
            by0_in   = (y_ff < mny) ? mny : y_ff;
            fail0_in = (!(x_ff < mnx) && (x_ff > mxx_ff)) ||
                       (!(y_ff < mny) && (y_ff > mxy_ff));
            state_in = ST_CCLIP;
         end
         ST_CCLIP: begin
            // tile off the rectangle: strips are cut around the raw tile
            fail_in  = fail_now;
            bx1_in   = (xhi && !fail_now) ? mxx_ff : x1_ff;
            by1_in   = (yhi && !fail_now) ? mxy_ff : y1_ff;
            bx0_in   = fail_now ? x_ff : bx0_ff;
            by0_in   = fail_now ? y_ff : by0_ff;
            state_in = ST_CSPAN;
         end
         ST_CSPAN: begin
            xl_in    = crd_max(mnx, bx0_ff);
            xr_in    = crd_min(mxx_ff, bx1_ff);
            piece_in = '0;
            state_in = ST_CFILL;
         end
         ST_CFILL: begin
            if (!want || emit_fire) begin
               if (piece_ff == 3'd4) state_in = ST_FLUSH;
               else                  piece_in = piece_ff + 3'd1;
            end
         end
         ST_FLUSH: begin
            if (!hold_valid_ff || out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold and output stages; the held command gets last only at flush
   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (emit_fire) begin
         if (hold_valid_ff) begin
            rsp_in       = hold_ff;
            rsp_valid_in = 1'b1;
         end
         hold_in       = gen_cmd;
         hold_valid_in = 1'b1;
      end else if (flush_fire) begin
         rsp_in        = hold_ff;
         rsp_in.last   = 1'b1;
         rsp_valid_in  = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pw_ff         <= 15'd16;
         ph_ff         <= 15'd16;
         center_ff     <= 1'b0;
         ready_ff      <= 1'b0;
         pen_ff        <= 8'd0;
      end else begin
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_PATTERN_WIDTH:  pw_ff     <= csr_wdata;
               CSR_PATTERN_HEIGHT: ph_ff     <= csr_wdata;
               CSR_CENTER_MODE:    center_ff <= csr_wdata[0];
               CSR_PATTERN_READY:  ready_ff  <= csr_wdata[0];
               CSR_BORDER_PEN:     pen_ff    <= csr_wdata[7:0];
               default:            ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      mxx_ff   <= mxx_in;
      mxy_ff   <= mxy_in;
      rw_ff    <= rw_in;
      rh_ff    <= rh_in;
      sx_ff    <= sx_in;
      sy_ff    <= sy_in;
      fw_ff    <= fw_in;
      fh_ff    <= fh_in;
      sw_ff    <= sw_in;
      sh_ff    <= sh_in;
      band_ff  <= band_in;
      rel_ff   <= rel_in;
      size_ff  <= size_in;
      piece_ff <= piece_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      x1_ff    <= x1_in;
      y1_ff    <= y1_in;
      bx0_ff   <= bx0_in;
      by0_ff   <= by0_in;
      bx1_ff   <= bx1_in;
      by1_ff   <= by1_in;
      xl_ff    <= xl_in;
      xr_ff    <= xr_in;
      fail0_ff <= fail0_in;
      fail_ff  <= fail_in;
      hold_ff  <= hold_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_valid_ff)
      else $error("held command left behind at idle");

   a_fill_no_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.cmd_kind == KIND_FILL) |->
         (rsp_ff.src_x == '0 && rsp_ff.src_y == '0))
      else $error("fill command with nonzero source");

   a_copy_no_pen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.cmd_kind != KIND_FILL) |-> rsp_ff.fill_pen == '0)
      else $error("copy command with a pen");

   a_nonzero_area: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.size_w != '0 && rsp_ff.size_h != '0))
      else $error("command with empty area");

endmodule

FILE: rtl/core/tfbp_mod.sv
// ----------------------------------------------------------------------------
// tfbp_mod
// Iterative non-negative modulo: restoring remainder, one dividend bit per
// cycle, then a sign fixup step.
// ----------------------------------------------------------------------------
module tfbp_mod (
   input  logic                  clock,
   input  logic                  reset,
   input  tfbp_pkg::mod_req_type mod_req,
   output tfbp_pkg::mod_rsp_type mod_rsp
);
   import tfbp_pkg::*;

   localparam int CNT_W = $clog2(MOD_STEPS);

   logic             run_ff, run_in;
   logic             fix_ff, fix_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      dvd_ff, dvd_in;
   len_type          rem_ff, rem_in;
   len_type          div_ff, div_in;
   logic             neg_ff, neg_in;
   len_type          res_ff, res_in;

   logic [15:0] shifted;
   logic [15:0] diff;

   assign shifted = {rem_ff, dvd_ff[15]};
   assign diff    = shifted - {1'b0, div_ff};

   always_comb begin
      run_in  = run_ff;
      fix_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      if (mod_req.start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         div_in = mod_req.divisor;
         neg_in = mod_req.dividend[15];
         dvd_in = mod_req.dividend[15] ? (~mod_req.dividend + 16'd1) : mod_req.dividend;
      end else if (run_ff) begin
         rem_in = (shifted >= {1'b0, div_ff}) ? diff[14:0] : shifted[14:0];
         dvd_in = {dvd_ff[14:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MOD_STEPS - 1)) begin
            run_in = 1'b0;
            fix_in = 1'b1;
         end
      end else if (fix_ff) begin
         res_in  = (neg_ff && rem_ff != '0) ? (div_ff - rem_ff) : rem_ff;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign mod_rsp.done   = done_ff;
   assign mod_rsp.result = res_ff;

   a_done_after_fix: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(fix_ff))
      else $error("modulo done without fixup step");

   a_res_below_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> res_ff < div_ff)
      else $error("modulo result not below divisor");

   a_run_fix_excl: assert property (@(posedge clock) disable iff (reset)
      !(run_ff && fix_ff))
      else $error("modulo run and fixup overlap");

endmodule
